// ===== hdl/pgcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgcr_pkg
// Shared types, constants and helpers of the proportional glyph column renderer.
// ----------------------------------------------------------------------------
package pgcr_pkg;

	localparam int GLYPH_COLUMNS = 8;
	localparam int COL_W = 8;
	localparam int OFS_W = 11;
	localparam int CNT_W = $clog2(GLYPH_COLUMNS + 1);
	localparam int LANE_IDX_W = $clog2(GLYPH_COLUMNS);

	localparam logic [7:0] SPACE_CODE = 8'd32;

	localparam logic signed [12:0] OFS_MIN = -13'sd1024;
	localparam logic signed [12:0] OFS_MAX = 13'sd1023;

	// configuration register indexes
	localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] CFG_GLYPH_GAP = 2'd2;
	localparam logic [1:0] CFG_SPACE_WIDTH = 2'd3;

	typedef logic [GLYPH_COLUMNS-1:0][COL_W-1:0] cols_t;

	typedef struct packed {
		logic [7:0] write_x;
		logic [7:0] pixel_bits;
		logic       clipped;
	} lane_res_t;

	// clamp a widened offset sum into the 11-bit signed range
	function automatic logic signed [OFS_W-1:0] sat_ofs(input logic signed [12:0] v);
		logic signed [12:0] r;
		r = v;
		if (v < OFS_MIN)
			r = OFS_MIN;
		else if (v > OFS_MAX)
			r = OFS_MAX;
		return r[OFS_W-1:0];
	endfunction

	// number of non-empty columns below column n
	function automatic logic [CNT_W-1:0] nz_below(input cols_t c, input int n);
		logic [CNT_W-1:0] cnt;
		cnt = '0;
		for (int i = 0; i < GLYPH_COLUMNS; i++) begin
			if (i < n && c[i] != '0)
				cnt = cnt + CNT_W'(1);
		end
		return cnt;
	endfunction

endpackage

// ===== hdl/pgcr_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgcr_lane
// One column lane: frame position, write column and clip flag of one column.
// ----------------------------------------------------------------------------
module pgcr_lane import pgcr_pkg::*; #(
	parameter int FRAME_WIDTH = 256
) (
	input  logic signed [OFS_W-1:0] base,
	input  logic [CNT_W-1:0]        prefix,
	input  logic [7:0]              origin_x,
	input  logic [COL_W-1:0]        col,
	output lane_res_t               res
);

	localparam logic signed [12:0] FW = 13'(FRAME_WIDTH);

	logic signed [OFS_W-1:0] ofs;
	logic signed [12:0]      pos;

	always_comb begin
		// offset only ever steps up within a glyph, so only the top bound can bite
		ofs = sat_ofs(13'(base) + $signed({{(13-CNT_W){1'b0}}, prefix}));
		pos = $signed({5'b0, origin_x}) + 13'(ofs);
		res.write_x = pos[7:0];
		res.pixel_bits = col;
		res.clipped = (pos < 13'sd0) || (pos >= FW);
	end

endmodule

// ===== hdl/pgcr_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgcr_serializer
// Merges the lane results of one glyph and sends them out one column a beat.
// ----------------------------------------------------------------------------
module pgcr_serializer import pgcr_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  lane_res_t [GLYPH_COLUMNS-1:0]  lanes,
	input  logic [5:0]                     top_row,
	output logic                           free,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [7:0]                     write_x,
	output logic [5:0]                     write_top_row,
	output logic [7:0]                     pixel_bits,
	output logic                           clipped,
	output logic                           last_of_glyph
);

	localparam logic [LANE_IDX_W-1:0] LAST_IDX = LANE_IDX_W'(GLYPH_COLUMNS - 1);

	lane_res_t [GLYPH_COLUMNS-1:0] ent_q;
	logic [5:0]                    top_q;
	logic [LANE_IDX_W-1:0]         cnt_q;
	logic                          busy_q;
	logic                          beat;
	logic                          last;

	assign beat = busy_q && !out_stall;
	assign last = cnt_q == LAST_IDX;
	assign free = !busy_q || (beat && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (beat) begin
			if (last)
				busy_q <= 1'b0;
			cnt_q <= cnt_q + LANE_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= lanes;
			top_q <= top_row;
		end
	end

	assign out_valid = busy_q;
	assign write_x = ent_q[cnt_q].write_x;
	assign pixel_bits = ent_q[cnt_q].pixel_bits;
	assign clipped = ent_q[cnt_q].clipped;
	assign write_top_row = top_q;
	assign last_of_glyph = last;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cnt_q))
		else $error("column index moved while output stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		beat && last && !load |=> !out_valid)
		else $error("serializer still busy after last column");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("glyph loaded over columns still pending");

endmodule

// ===== hdl/proportional_glyph_column_renderer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proportional_glyph_column_renderer_top
// Renders one character per beat into framebuffer column writes.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------
//   in      | in_valid / in_stall     | text_start, char_code, glyph_col0..7
//   out     | out_valid / out_stall   | write_x, write_top_row, pixel_bits,
//           |                         | clipped, last_of_glyph
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A glyph gives eight output beats, one a cycle unless out_stall holds them.
// A space is accepted at the input and gives no beat.
// Eight lanes place all columns of a glyph at once, one stage after acceptance.
// Reset clears the running offset and loads the register defaults.
// out_stall holds the current column; one glyph waits in the lane stage meanwhile.
// ----------------------------------------------------------------------------
module proportional_glyph_column_renderer_top import pgcr_pkg::*; #(
	parameter int FRAME_WIDTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        text_start,
	input  logic [7:0]  char_code,
	input  logic [7:0]  glyph_col0,
	input  logic [7:0]  glyph_col1,
	input  logic [7:0]  glyph_col2,
	input  logic [7:0]  glyph_col3,
	input  logic [7:0]  glyph_col4,
	input  logic [7:0]  glyph_col5,
	input  logic [7:0]  glyph_col6,
	input  logic [7:0]  glyph_col7,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  write_x,
	output logic [5:0]  write_top_row,
	output logic [7:0]  pixel_bits,
	output logic        clipped,
	output logic        last_of_glyph
);

	logic [7:0]              origin_x_q;
	logic [5:0]              origin_y_q;
	logic signed [7:0]       glyph_gap_q;
	logic [7:0]              space_width_q;
	logic signed [OFS_W-1:0] ofs_q;

	logic                    valid_s1;
	logic signed [OFS_W-1:0] base_s1;
	cols_t                   cols_s1;

	cols_t                   cols_in;
	logic                    acc;
	logic                    is_space;
	logic                    ser_free;
	logic                    ser_load;
	logic signed [OFS_W-1:0] base_in;
	logic signed [OFS_W-1:0] ofs_glyph;
	logic signed [OFS_W-1:0] ofs_nxt;
	logic [CNT_W-1:0]        nz_all;

	lane_res_t [GLYPH_COLUMNS-1:0] lanes;

	assign cols_in = {glyph_col7, glyph_col6, glyph_col5, glyph_col4,
		glyph_col3, glyph_col2, glyph_col1, glyph_col0};

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= 8'd0;
			origin_y_q <= 6'd0;
			glyph_gap_q <= 8'sd1;
			space_width_q <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:    origin_x_q <= cfg_data;
				CFG_ORIGIN_Y:    origin_y_q <= cfg_data[5:0];
				CFG_GLYPH_GAP:   glyph_gap_q <= $signed(cfg_data);
				CFG_SPACE_WIDTH: space_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = valid_s1 && !ser_free;
	assign acc = in_valid && !in_stall;
	assign is_space = char_code == SPACE_CODE;
	assign ser_load = valid_s1 && ser_free;

	// offset left behind by this beat, resolved at acceptance for the next one
	always_comb begin
		base_in = text_start ? '0 : ofs_q;
		nz_all = nz_below(cols_in, GLYPH_COLUMNS);
		ofs_glyph = sat_ofs(13'(base_in) + $signed({{(13-CNT_W){1'b0}}, nz_all}));
		if (is_space)
			ofs_nxt = sat_ofs(13'(base_in) + $signed({5'b0, space_width_q}) - 13'sd1);
		else
			ofs_nxt = sat_ofs(13'(ofs_glyph) + 13'(glyph_gap_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (acc)
				ofs_q <= ofs_nxt;
			if (acc && !is_space)
				valid_s1 <= 1'b1;
			else if (ser_load)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !is_space) begin
			base_s1 <= base_in;
			cols_s1 <= cols_in;
		end
	end

	for (genvar j = 0; j < GLYPH_COLUMNS; j++) begin : g_lane
		pgcr_lane #(
			.FRAME_WIDTH(FRAME_WIDTH)
		) u_lane (
			.base     (base_s1),
			.prefix   (nz_below(cols_s1, j)),
			.origin_x (origin_x_q),
			.col      (cols_s1[j]),
			.res      (lanes[j])
		);
	end

	pgcr_serializer u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (ser_load),
		.lanes         (lanes),
		.top_row       (origin_y_q),
		.free          (ser_free),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.write_x       (write_x),
		.write_top_row (write_top_row),
		.pixel_bits    (pixel_bits),
		.clipped       (clipped),
		.last_of_glyph (last_of_glyph)
	);

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty lane stage");

	a_glyph_held: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !is_space |=> valid_s1)
		else $error("accepted glyph did not reach lane stage");

	a_space_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_space && !valid_s1 |=> !valid_s1)
		else $error("space entered the lane stage");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the glyph column renderer against an in-bench model of the running
// column offset. Directed texts cover clipping on both sides, offset
// saturation, zero space width and control codes. Random texts then run under
// several source/sink idling mixes and register settings, including a long
// sink hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------
module tb;
	import pgcr_pkg::*;

	localparam int FRAME_W = 256;
	localparam int OFFSET_FLOOR = -1024;
	localparam int OFFSET_CEIL = 1023;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 4;
	localparam int CHARS_PER_PHASE = 36;

	typedef struct packed {
		logic            text_start;
		logic [7:0]      char_code;
		logic [7:0][7:0] cols;
	} char_beat_t;

	typedef struct packed {
		logic [7:0] write_x;
		logic [5:0] write_top_row;
		logic [7:0] pixel_bits;
		logic       clipped;
		logic       last_of_glyph;
	} column_write_t;

	// running-offset model plus queue of column writes still owed by the block
	class glyph_column_tracker;
		logic [7:0]         origin_x;
		logic [5:0]         origin_y;
		logic signed [7:0]  glyph_gap;
		logic [7:0]         space_width;
		logic signed [10:0] offset;
		column_write_t      pending_columns[$];
		int                 mismatches;

		function new();
			origin_x = '0;
			origin_y = '0;
			glyph_gap = 8'sd1;
			space_width = 8'd3;
			offset = '0;
			mismatches = 0;
		endfunction

		function logic signed [10:0] clamp(int v);
			if (v < OFFSET_FLOOR)
				return 11'(OFFSET_FLOOR);
			if (v > OFFSET_CEIL)
				return 11'(OFFSET_CEIL);
			return 11'(v);
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				CFG_ORIGIN_X: origin_x = val;
				CFG_ORIGIN_Y: origin_y = val[5:0];
				CFG_GLYPH_GAP: glyph_gap = val;
				CFG_SPACE_WIDTH: space_width = val;
				default: ;
			endcase
		endfunction

		function void note_char(char_beat_t c);
			int            pos;
			column_write_t w;
			if (c.text_start)
				offset = '0;
			if (c.char_code == SPACE_CODE) begin
				offset = clamp(int'(offset) + int'(space_width) - 1);
				return;
			end
			for (int j = 0; j < GLYPH_COLUMNS; j++) begin
				pos = int'(origin_x) + int'(offset);
				w.write_x = pos[7:0];
				w.write_top_row = origin_y;
				w.pixel_bits = c.cols[j];
				w.clipped = (pos < 0) || (pos >= FRAME_W);
				w.last_of_glyph = (j == GLYPH_COLUMNS - 1);
				pending_columns.push_back(w);
				// empty columns do not advance, so the next one lands on top
				if (c.cols[j] != '0)
					offset = clamp(int'(offset) + 1);
			end
			offset = clamp(int'(offset) + int'(glyph_gap));
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_column(logic [7:0] x, logic [5:0] top, logic [7:0] bits,
				logic clip, logic last);
			column_write_t want;
			if (pending_columns.size() == 0) begin
				$error("unexpected column write: write_x 0x%0h pixel_bits 0x%0h", x, bits);
				mismatches++;
				return;
			end
			want = pending_columns.pop_front();
			compare_field("write_x", want.write_x, x);
			compare_field("write_top_row", 8'(want.write_top_row), 8'(top));
			compare_field("pixel_bits", want.pixel_bits, bits);
			compare_field("clipped", 8'(want.clipped), 8'(clip));
			compare_field("last_of_glyph", 8'(want.last_of_glyph), 8'(last));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic       text_start;
	logic [7:0] char_code;
	logic [7:0] glyph_col0, glyph_col1, glyph_col2, glyph_col3;
	logic [7:0] glyph_col4, glyph_col5, glyph_col6, glyph_col7;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] write_x;
	logic [5:0] write_top_row;
	logic [7:0] pixel_bits;
	logic       clipped;
	logic       last_of_glyph;

	glyph_column_tracker sb;
	int send_idle_pct;
	int stall_pct;
	int hold_requests;
	int cycle_count;

	proportional_glyph_column_renderer_top #(
		.FRAME_WIDTH(FRAME_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_start(text_start),
		.char_code(char_code),
		.glyph_col0(glyph_col0),
		.glyph_col1(glyph_col1),
		.glyph_col2(glyph_col2),
		.glyph_col3(glyph_col3),
		.glyph_col4(glyph_col4),
		.glyph_col5(glyph_col5),
		.glyph_col6(glyph_col6),
		.glyph_col7(glyph_col7),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.write_x(write_x),
		.write_top_row(write_top_row),
		.pixel_bits(pixel_bits),
		.clipped(clipped),
		.last_of_glyph(last_of_glyph)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// sink side: random stalls, plus a long hold-off on request
	initial begin : sink_stall
		int served;
		served = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != served) begin
				served++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			sb.check_column(write_x, write_top_row, pixel_bits, clipped, last_of_glyph);
	end

	function automatic char_beat_t mk_char(logic ts, logic [7:0] code, logic [63:0] cols);
		char_beat_t c;
		c.text_start = ts;
		c.char_code = code;
		c.cols = cols;
		return c;
	endfunction

	function automatic char_beat_t random_char(bit first);
		char_beat_t c;
		c.text_start = first ? 1'b1 : ($urandom_range(19) == 0);
		case ($urandom_range(9))
			0, 1: c.char_code = SPACE_CODE;
			default: c.char_code = 8'($urandom_range(255));
		endcase
		for (int j = 0; j < GLYPH_COLUMNS; j++) begin
			case ($urandom_range(5))
				0, 1: c.cols[j] = '0;
				2: c.cols[j] = '1;
				default: c.cols[j] = 8'($urandom_range(255));
			endcase
		end
		return c;
	endfunction

	task automatic send_char(char_beat_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_start <= c.text_start;
		char_code <= c.char_code;
		glyph_col0 <= c.cols[0];
		glyph_col1 <= c.cols[1];
		glyph_col2 <= c.cols[2];
		glyph_col3 <= c.cols[3];
		glyph_col4 <= c.cols[4];
		glyph_col5 <= c.cols[5];
		glyph_col6 <= c.cols[6];
		glyph_col7 <= c.cols[7];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_char(c);
		@(negedge clk);
	endtask

	task automatic write_regs(logic [7:0] ox, logic [5:0] oy, logic [7:0] gap,
			logic [7:0] sw);
		logic [1:0] idx[4];
		logic [7:0] val[4];
		idx = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_GLYPH_GAP, CFG_SPACE_WIDTH};
		val = '{ox, {2'b00, oy}, gap, sw};
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.set_reg(idx[k], val[k]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// spaces leave no beat behind, so let the block drain past the last one
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_columns.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int idle_mix[RANDOM_PHASES];
		int stall_mix[RANDOM_PHASES];
		int sent;
		int len;
		sb = new();
		idle_mix = '{0, 85, 0, 13};
		stall_mix = '{0, 0, 85, 13};
		send_idle_pct = 0;
		stall_pct = 0;
		hold_requests = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		text_start = 1'b0;
		char_code = '0;
		{glyph_col0, glyph_col1, glyph_col2, glyph_col3} = '0;
		{glyph_col4, glyph_col5, glyph_col6, glyph_col7} = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: plain glyphs, empty and full columns, control codes
		send_char(mk_char(1'b1, 8'h41, 64'h00_3C_42_42_7E_42_42_00));
		send_char(mk_char(1'b0, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF));
		send_char(mk_char(1'b0, 8'hFF, 64'h0));
		send_char(mk_char(1'b0, SPACE_CODE, 64'hA5A5_A5A5_A5A5_A5A5));
		send_char(mk_char(1'b1, SPACE_CODE, 64'h0));
		send_char(mk_char(1'b0, 8'h7F, 64'h0102_0408_1020_4080));
		wait_idle();

		// right edge, rows past the frame, zero space width, run down to the floor
		write_regs(8'hFF, 6'd63, 8'h80, 8'h00);
		send_char(mk_char(1'b1, SPACE_CODE, 64'h0));
		for (int k = 0; k < 9; k++)
			send_char(mk_char(1'b0, 8'(8'h21 + k), 64'h0000_0000_0000_0080));
		wait_idle();

		// widest space and gap, climb to the ceiling and clip past the frame
		write_regs(8'h00, 6'd56, 8'h7F, 8'hFF);
		send_char(mk_char(1'b1, 8'h58, 64'hFFFF_FFFF_FFFF_FFFF));
		for (int k = 0; k < 5; k++)
			send_char(mk_char(1'b0, SPACE_CODE, 64'h0));
		send_char(mk_char(1'b0, 8'h80, 64'hFFFF_FFFF_FFFF_FFFF));
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_regs(8'($urandom_range(255)), 6'($urandom_range(63)),
				($urandom_range(1) != 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255)),
				($urandom_range(1) != 0) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(255)));
			send_idle_pct = idle_mix[p];
			stall_pct = stall_mix[p];
			if (p == 0)
				hold_requests++;
			sent = 0;
			while (sent < CHARS_PER_PHASE) begin
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++) begin
					send_char(random_char(k == 0));
					sent++;
				end
			end
			wait_idle();
		end

		if (sb.mismatches == 0 && sb.pending_columns.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
